[hw/rtl/lpht_pkg.sv]
// ----------------------------------------------------------------------------
// lpht_pkg
// shared constants, command and status codes and sequencer states of the
// linear probing hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int MAX_SLOTS_DEF = 1024;
  localparam int KEY_BITS_DEF  = 31;
  localparam int RESET_SIZE    = 11;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_READ   = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_SIZE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_SLOT_KEY  = 3'd4,
    ST_SLOT_EMPTY = 3'd5,
    ST_SIZE      = 3'd6,
    ST_BAD_INDEX = 3'd7
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SLOT_RD,
    S_SLOT_CHK,
    S_PRIME_TEST,
    S_PRIME_MOD,
    S_BANK_CLR,
    S_RH_RD,
    S_RH_CHK,
    S_PR_MOD,
    S_PR_RD,
    S_PR_CHK,
    S_DONE
  } state_t;

endpackage

[hw/rtl/lpht_if.sv]
// ----------------------------------------------------------------------------
// lpht channel interfaces
// valid/ready channels for items, results and the size register
// ----------------------------------------------------------------------------
interface lpht_in_if #(parameter int KW = 31, parameter int IW = 10);
  logic          valid;
  logic          ready;
  logic [1:0]    cmd;
  logic [KW-1:0] key;
  logic [IW-1:0] slot_index;

  modport source (output valid, cmd, key, slot_index, input ready);
  modport sink   (input valid, cmd, key, slot_index, output ready);
endinterface

interface lpht_out_if #(parameter int KW = 31, parameter int SW = 11);
  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [KW-1:0] slot_key;
  logic [SW-1:0] table_size;

  modport source (output valid, status, slot_key, table_size, input ready);
  modport sink   (input valid, status, slot_key, table_size, output ready);
endinterface

interface lpht_cfg_if #(parameter int SW = 11);
  logic          valid;
  logic          ready;
  logic [SW-1:0] initial_size;

  modport source (output valid, initial_size, input ready);
  modport sink   (input valid, initial_size, output ready);
endinterface

[hw/rtl/lpht_mod_unit.sv]
// ----------------------------------------------------------------------------
// lpht_mod_unit
// shared restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
module lpht_mod_unit #(
  parameter int DW = 31,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] rem
);
  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    dvd_r;
  logic [VW-1:0]    div_r;
  logic [VW-1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [VW:0]      trial;
  logic             ge;
  logic [VW-1:0]    rem_nxt;

  always_comb begin
    trial   = {rem_r, dvd_r[DW-1]};
    ge      = trial >= {1'b0, div_r};
    rem_nxt = ge ? VW'(trial - {1'b0, div_r}) : VW'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(DW);
    end else if (busy_r) begin
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CNT_W'(1));
      done_r <= (cnt_r == CNT_W'(1));
    end else begin
      done_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[hw/rtl/lpht_store.sv]
// ----------------------------------------------------------------------------
// lpht_store
// two-bank slot memory, valid bit above the key, registered read
// ----------------------------------------------------------------------------
module lpht_store #(
  parameter int AW    = 11,
  parameter int DEPTH = 2048,
  parameter int MW    = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [MW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [MW-1:0] rdata
);
  logic [MW-1:0] mem [DEPTH];
  logic [MW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/linear_probe_hash_table_top.sv]
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// open-addressing hash table with linear probing and growth to a prime size
// ----------------------------------------------------------------------------
// One command per transfer, one result per command. After reset the block
// sweeps its whole slot memory, both banks, before it takes the first item.
// A size read goes from idle straight to the result state; a slot read first
// passes a slot read and a slot check state. Search and insert run the home
// slot through the shared remainder unit and then read and check each probed
// slot over the single memory read port. An insert that grows the table adds
// a prime search by trial division on that same remainder unit, a clear of
// the new bank and, for every held key, one remainder plus its probes. The
// result register lets the next item be taken while a result waits.
module linear_probe_hash_table_top #(
  parameter int MAX_SLOTS = lpht_pkg::MAX_SLOTS_DEF,
  parameter int KEY_BITS  = lpht_pkg::KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  lpht_in_if.sink     in_ch,
  lpht_out_if.source  out_ch,
  lpht_cfg_if.sink    cfg_ch
);
  import lpht_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SLOTS);
  localparam int SIZE_W = IDX_W + 1;
  localparam int CW     = SIZE_W + 1;
  localparam int AW     = $clog2(2 * MAX_SLOTS);
  localparam int DW     = (KEY_BITS > CW) ? KEY_BITS : CW;
  localparam int MW     = KEY_BITS + 1;
  localparam int SQ_W   = 2 * SIZE_W;
  localparam logic [SIZE_W-1:0] SIZE_RST =
    SIZE_W'((RESET_SIZE > MAX_SLOTS) ? MAX_SLOTS : RESET_SIZE);

  // sequencer and table state
  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic                active_r, active_nxt;
  logic [SIZE_W-1:0]   cur_size_r, cur_size_nxt;
  logic [SIZE_W-1:0]   occ_r, occ_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                mod_run_r, mod_run_nxt;

  // working registers of the current command
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]       cand_r, cand_nxt;
  logic [SIZE_W-1:0]   div_r, div_nxt;
  logic [SIZE_W-1:0]   rh_idx_r, rh_idx_nxt;
  logic [KEY_BITS-1:0] pr_key_r, pr_key_nxt;
  logic [SIZE_W-1:0]   pr_size_r, pr_size_nxt;
  logic                pr_bank_r, pr_bank_nxt;
  logic [IDX_W-1:0]    pr_pos_r, pr_pos_nxt;
  logic [SIZE_W-1:0]   pr_cnt_r, pr_cnt_nxt;
  logic                pr_search_r, pr_search_nxt;
  logic                pr_rehash_r, pr_rehash_nxt;
  status_t             res_status_r, res_status_nxt;
  logic [KEY_BITS-1:0] res_key_r, res_key_nxt;

  // result register
  logic [2:0]          out_status_r;
  logic [KEY_BITS-1:0] out_key_r;
  logic [SIZE_W-1:0]   out_size_r;

  // memory and remainder unit hookup
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [MW-1:0]       mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [MW-1:0]       mem_rdata;
  logic                mod_start;
  logic [DW-1:0]       mod_dividend;
  logic [SIZE_W-1:0]   mod_divisor;
  logic                mod_done;
  logic [SIZE_W-1:0]   mod_rem;

  // decoded conditions
  logic                in_xfer, out_xfer, cfg_xfer, res_load;
  logic                rd_valid;
  logic [KEY_BITS-1:0] rd_key;
  logic [SIZE_W:0]     occ_p1;
  logic                need_grow;
  logic [CW-1:0]       first_cand;
  logic                first_over;
  logic [CW-1:0]       cand_p1;
  logic                cand_over;
  logic [SQ_W-1:0]     div_sq;
  logic                prime_found;
  logic [AW-1:0]       old_base, new_base, pr_base;
  logic                rh_done;
  logic                pos_last, cnt_last;
  logic [IDX_W-1:0]    pos_adv;
  logic [SIZE_W-1:0]   cfg_size;

  assign in_xfer  = in_ch.valid & in_ch.ready;
  assign out_xfer = out_ch.valid & out_ch.ready;
  assign cfg_xfer = cfg_ch.valid & cfg_ch.ready;
  assign res_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign rd_valid = mem_rdata[MW-1];
  assign rd_key   = mem_rdata[KEY_BITS-1:0];

  // load check: grow when 2*(occupied+1) exceeds the size
  assign occ_p1     = {1'b0, occ_r} + 1'b1;
  assign need_grow  = {occ_p1, 1'b0} > (SIZE_W + 2)'(cur_size_r);
  assign first_cand = {cur_size_r, 1'b0} + 1'b1;
  assign first_over = first_cand > CW'(MAX_SLOTS);
  assign cand_p1    = cand_r + 1'b1;
  assign cand_over  = cand_p1 > CW'(MAX_SLOTS);
  assign div_sq     = div_r * div_r;
  assign prime_found = div_sq > SQ_W'(cand_r);

  assign old_base = active_r ? AW'(MAX_SLOTS) : '0;
  assign new_base = active_r ? '0 : AW'(MAX_SLOTS);
  assign pr_base  = pr_bank_r ? AW'(MAX_SLOTS) : '0;
  assign rh_done  = rh_idx_r == cur_size_r;

  // probe step with wrap at the size in use
  assign pos_last = ({1'b0, pr_pos_r} + 1'b1) == pr_size_r;
  assign pos_adv  = pos_last ? '0 : pr_pos_r + 1'b1;
  assign cnt_last = (pr_cnt_r + 1'b1) == pr_size_r;

  // a zero size reads as one, anything above the limit saturates
  always_comb begin
    if (cfg_ch.initial_size == '0) begin
      cfg_size = SIZE_W'(1);
    end else if (SIZE_W'(cfg_ch.initial_size) > SIZE_W'(MAX_SLOTS)) begin
      cfg_size = SIZE_W'(MAX_SLOTS);
    end else begin
      cfg_size = SIZE_W'(cfg_ch.initial_size);
    end
  end

  lpht_mod_unit #(
    .DW (DW),
    .VW (SIZE_W)
  ) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dividend),
    .divisor  (mod_divisor),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  lpht_store #(
    .AW    (AW),
    .DEPTH (2 * MAX_SLOTS),
    .MW    (MW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(2 * MAX_SLOTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_xfer) begin
          case (cmd_t'(in_ch.cmd))
            CMD_INSERT: begin
              if (!need_grow) state_nxt = S_PR_MOD;
              else if (first_over) state_nxt = S_DONE;
              else state_nxt = S_PRIME_TEST;
            end
            CMD_READ: begin
              if (SIZE_W'(in_ch.slot_index) >= cur_size_r) state_nxt = S_DONE;
              else state_nxt = S_SLOT_RD;
            end
            CMD_SEARCH: state_nxt = S_PR_MOD;
            default:    state_nxt = S_DONE;
          endcase
        end
      end
      S_SLOT_RD:    state_nxt = S_SLOT_CHK;
      S_SLOT_CHK:   state_nxt = S_DONE;
      S_PRIME_TEST: state_nxt = prime_found ? S_BANK_CLR : S_PRIME_MOD;
      S_PRIME_MOD: begin
        if (mod_done) begin
          if (mod_rem == '0 && cand_over) state_nxt = S_DONE;
          else state_nxt = S_PRIME_TEST;
        end
      end
      S_BANK_CLR: begin
        if (clr_r == AW'(MAX_SLOTS - 1)) state_nxt = S_RH_RD;
      end
      S_RH_RD:  state_nxt = rh_done ? S_PR_MOD : S_RH_CHK;
      S_RH_CHK: state_nxt = rd_valid ? S_PR_MOD : S_RH_RD;
      S_PR_MOD: begin
        if (mod_done) state_nxt = S_PR_RD;
      end
      S_PR_RD: state_nxt = S_PR_CHK;
      S_PR_CHK: begin
        if (pr_search_r) begin
          if (!rd_valid || rd_key == pr_key_r || cnt_last) state_nxt = S_DONE;
          else state_nxt = S_PR_RD;
        end else if (!rd_valid || cnt_last) begin
          state_nxt = pr_rehash_r ? S_RH_RD : S_DONE;
        end else begin
          state_nxt = S_PR_RD;
        end
      end
      S_DONE: begin
        if (res_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath register updates
  always_comb begin
    clr_nxt        = clr_r;
    active_nxt     = active_r;
    cur_size_nxt   = cur_size_r;
    occ_nxt        = occ_r;
    out_valid_nxt  = out_valid_r;
    mod_run_nxt    = mod_run_r;
    key_nxt        = key_r;
    idx_nxt        = idx_r;
    cand_nxt       = cand_r;
    div_nxt        = div_r;
    rh_idx_nxt     = rh_idx_r;
    pr_key_nxt     = pr_key_r;
    pr_size_nxt    = pr_size_r;
    pr_bank_nxt    = pr_bank_r;
    pr_pos_nxt     = pr_pos_r;
    pr_cnt_nxt     = pr_cnt_r;
    pr_search_nxt  = pr_search_r;
    pr_rehash_nxt  = pr_rehash_r;
    res_status_nxt = res_status_r;
    res_key_nxt    = res_key_r;

    if (out_xfer) out_valid_nxt = 1'b0;
    if (mod_start) mod_run_nxt = 1'b1;
    else if (mod_done) mod_run_nxt = 1'b0;

    // size register write, taken into the table only while it is empty
    if (cfg_xfer && occ_r == '0) cur_size_nxt = cfg_size;

    case (state_r)
      S_CLEAR: clr_nxt = clr_r + 1'b1;
      S_IDLE: begin
        res_key_nxt = '0;
        if (in_xfer) begin
          key_nxt       = in_ch.key;
          idx_nxt       = in_ch.slot_index;
          pr_key_nxt    = in_ch.key;
          pr_size_nxt   = cur_size_r;
          pr_bank_nxt   = active_r;
          pr_search_nxt = (cmd_t'(in_ch.cmd) == CMD_SEARCH);
          pr_rehash_nxt = 1'b0;
          cand_nxt      = first_cand;
          div_nxt       = SIZE_W'(2);
          case (cmd_t'(in_ch.cmd))
            CMD_INSERT: res_status_nxt = ST_REFUSED;
            CMD_READ:   res_status_nxt = ST_BAD_INDEX;
            CMD_SEARCH: res_status_nxt = ST_NOT_FOUND;
            default:    res_status_nxt = ST_SIZE;
          endcase
        end
      end
      S_SLOT_CHK: begin
        if (rd_valid) begin
          res_status_nxt = ST_SLOT_KEY;
          res_key_nxt    = rd_key;
        end else begin
          res_status_nxt = ST_SLOT_EMPTY;
        end
      end
      S_PRIME_TEST: clr_nxt = '0;
      S_PRIME_MOD: begin
        if (mod_done) begin
          if (mod_rem == '0) begin
            cand_nxt = cand_p1;
            div_nxt  = SIZE_W'(2);
          end else begin
            div_nxt = div_r + 1'b1;
          end
        end
      end
      S_BANK_CLR: begin
        clr_nxt    = clr_r + 1'b1;
        rh_idx_nxt = '0;
      end
      S_RH_RD: begin
        if (rh_done) begin
          // swap banks, then place the new key in the grown table
          active_nxt    = !active_r;
          cur_size_nxt  = SIZE_W'(cand_r);
          pr_key_nxt    = key_r;
          pr_size_nxt   = SIZE_W'(cand_r);
          pr_bank_nxt   = !active_r;
          pr_rehash_nxt = 1'b0;
        end
      end
      S_RH_CHK: begin
        if (rd_valid) begin
          pr_key_nxt    = rd_key;
          pr_size_nxt   = SIZE_W'(cand_r);
          pr_bank_nxt   = !active_r;
          pr_rehash_nxt = 1'b1;
        end else begin
          rh_idx_nxt = rh_idx_r + 1'b1;
        end
      end
      S_PR_MOD: begin
        if (mod_done) begin
          pr_pos_nxt = IDX_W'(mod_rem);
          pr_cnt_nxt = '0;
        end
      end
      S_PR_CHK: begin
        pr_pos_nxt = pos_adv;
        pr_cnt_nxt = pr_cnt_r + 1'b1;
        if (pr_search_r) begin
          if (rd_valid && rd_key == pr_key_r) res_status_nxt = ST_FOUND;
        end else if (!rd_valid || cnt_last) begin
          if (pr_rehash_r) begin
            rh_idx_nxt = rh_idx_r + 1'b1;
          end else begin
            occ_nxt        = occ_r + 1'b1;
            res_status_nxt = ST_INSERTED;
          end
        end
      end
      S_DONE: begin
        if (res_load) out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // memory, remainder unit and port controls
  always_comb begin
    mem_we       = 1'b0;
    mem_waddr    = pr_base + AW'(pr_pos_r);
    mem_wdata    = {1'b1, pr_key_r};
    mem_raddr    = pr_base + AW'(pr_pos_r);
    mod_start    = 1'b0;
    mod_dividend = DW'(pr_key_r);
    mod_divisor  = pr_size_r;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
      end
      S_SLOT_RD: mem_raddr = old_base + AW'(idx_r);
      S_PRIME_MOD: begin
        mod_start    = !mod_run_r;
        mod_dividend = DW'(cand_r);
        mod_divisor  = div_r;
      end
      S_BANK_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = new_base + clr_r;
        mem_wdata = '0;
      end
      S_RH_RD:  mem_raddr = old_base + AW'(rh_idx_r);
      S_PR_MOD: mod_start = !mod_run_r;
      S_PR_CHK: mem_we = !pr_search_r && !rd_valid;
      default: ;
    endcase
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign cfg_ch.ready      = 1'b1;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_key   = out_key_r;
  assign out_ch.table_size = out_size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      active_r    <= 1'b0;
      cur_size_r  <= SIZE_RST;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
      mod_run_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      active_r    <= active_nxt;
      cur_size_r  <= cur_size_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
      mod_run_r   <= mod_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    idx_r        <= idx_nxt;
    cand_r       <= cand_nxt;
    div_r        <= div_nxt;
    rh_idx_r     <= rh_idx_nxt;
    pr_key_r     <= pr_key_nxt;
    pr_size_r    <= pr_size_nxt;
    pr_bank_r    <= pr_bank_nxt;
    pr_pos_r     <= pr_pos_nxt;
    pr_cnt_r     <= pr_cnt_nxt;
    pr_search_r  <= pr_search_nxt;
    pr_rehash_r  <= pr_rehash_nxt;
    res_status_r <= res_status_nxt;
    res_key_r    <= res_key_nxt;
    if (res_load) begin
      out_status_r <= res_status_r;
      out_key_r    <= res_key_r;
      out_size_r   <= cur_size_r;
    end
  end

  // the load rule keeps the count within the table
  a_occ_in_size: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> occ_r <= cur_size_r)
    else $error("occupied count above table size");

  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_size_r != '0 && cur_size_r <= SIZE_W'(MAX_SLOTS))
    else $error("table size out of range");

  a_mod_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_PR_MOD || state_r == S_PRIME_MOD))
    else $error("remainder finished outside a waiting state");

  a_probe_write: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && state_r == S_PR_CHK) |-> !rd_valid)
    else $error("probe wrote over an occupied slot");

  a_item_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r != S_IDLE)
    else $error("accepted item did not start work");

endmodule
